/* hw/rtl/two_link_forward_kinematics_jacobian_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the two-link kinematics core
// ---------------------------------------------------------------------------
`ifndef TWO_LINK_FORWARD_KINEMATICS_JACOBIAN_CORE_MACROS_SVH
`define TWO_LINK_FORWARD_KINEMATICS_JACOBIAN_CORE_MACROS_SVH

// implication checked on every clock, quiet while in reset
`define TLK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TLK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/tlk_pkg.sv */
// ---------------------------------------------------------------------------
// tlk_pkg
// Shared types and constants of the two-link kinematics core.
// ---------------------------------------------------------------------------
package tlk_pkg;

  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic [1:0] CfgThigh = 2'd0;
  localparam logic [1:0] CfgCalf  = 2'd1;

  // one CORDIC vector in flight; Q2.30 with guard bits
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
  } cvec_t;

  function automatic logic signed [32:0] atan_lut(input int i);
    logic signed [32:0] r;
    r = '0;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;  2: r = 33'sd167458907;
      3: r = 33'sd85004756;    4: r = 33'sd42667331;   5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;    8: r = 33'sd2670163;
      9: r = 33'sd1335087;     10: r = 33'sd667544;    11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;     14: r = 33'sd41722;
      15: r = 33'sd20861;      16: r = 33'sd10430;     17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;      20: r = 33'sd652;
      21: r = 33'sd326;        22: r = 33'sd163;       23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // range fold before the first stage
  function automatic cvec_t cordic_seed(input logic signed [15:0] a);
    cvec_t v;
    logic signed [16:0] aa;
    aa = 17'(a);
    v.flip = 1'b0;
    if (aa > 17'sd16384) begin
      aa = aa - 17'sd32768;
      v.flip = 1'b1;
    end else if (aa < -17'sd16384) begin
      aa = aa + 17'sd32768;
      v.flip = 1'b1;
    end
    v.x = CordicX0;
    v.y = '0;
    v.z = {aa[16:0], 16'd0};
    return v;
  endfunction

  // Q2.30 to Q1.15, rounded, saturated, sign restored
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v,
                                                input logic flip);
    logic signed [34:0] t;
    logic signed [19:0] r;
    t = 35'(v) + 35'sd16384;
    r = 20'(t >>> 15);
    if (r > 20'sd32767) r = 20'sd32767;
    else if (r < -20'sd32767) r = -20'sd32767;
    if (flip) r = -r;
    return r[15:0];
  endfunction

endpackage

/* hw/rtl/tlk_cordic_cell.sv */
// ---------------------------------------------------------------------------
// tlk_cordic_cell
// One rotation stage; carries both angles plus the pose side data onward.
// ---------------------------------------------------------------------------
module tlk_cordic_cell #(
  parameter int STAGE = 0,
  parameter int LW    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 stall,
  input  logic                 vld_i,
  input  tlk_pkg::cvec_t       a_i,
  input  tlk_pkg::cvec_t       b_i,
  input  logic [LW-1:0]        tl_i,
  input  logic [LW-1:0]        cl_i,
  output logic                 vld_o,
  output tlk_pkg::cvec_t       a_o,
  output tlk_pkg::cvec_t       b_o,
  output logic [LW-1:0]        tl_o,
  output logic [LW-1:0]        cl_o
);

  localparam int Sh = (STAGE < 34) ? STAGE : 33;
  localparam logic signed [32:0] Da = tlk_pkg::atan_lut(STAGE);

  logic           vld_r;
  tlk_pkg::cvec_t a_r, b_r, a_nxt, b_nxt;
  logic [LW-1:0]  tl_r, cl_r;

  function automatic tlk_pkg::cvec_t rot(input tlk_pkg::cvec_t v);
    tlk_pkg::cvec_t o;
    o = v;
    if (!v.z[32]) begin
      o.x = v.x - (v.y >>> Sh);
      o.y = v.y + (v.x >>> Sh);
      o.z = v.z - Da;
    end else begin
      o.x = v.x + (v.y >>> Sh);
      o.y = v.y - (v.x >>> Sh);
      o.z = v.z + Da;
    end
    return o;
  endfunction

  always_comb begin
    a_nxt = rot(a_i);
    b_nxt = rot(b_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!stall) begin
      vld_r <= vld_i;
    end
    if (!stall) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      tl_r <= tl_i;
      cl_r <= cl_i;
    end
  end

  assign vld_o = vld_r;
  assign a_o   = a_r;
  assign b_o   = b_r;
  assign tl_o  = tl_r;
  assign cl_o  = cl_r;

endmodule

/* hw/rtl/tlk_combine.sv */
// ---------------------------------------------------------------------------
// tlk_combine
// Length products (registered), then sums, saturation and output register.
// ---------------------------------------------------------------------------
module tlk_combine #(
  parameter int LW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           stall,
  input  logic           vld_i,
  input  tlk_pkg::cvec_t a_i,
  input  tlk_pkg::cvec_t b_i,
  input  logic [LW-1:0]  tl_i,
  input  logic [LW-1:0]  cl_i,
  output logic           vld_o,
  output logic [107:0]   res_o
);

  localparam int PW = LW + 2;
  // sum width, never below what the 18 bit clamp needs
  localparam int SW = (PW + 2 > 19) ? PW + 2 : 19;

  logic signed [15:0] ct, st, ck, sk;
  logic               p_vld_r;
  logic signed [PW-1:0] tc_r, ts_r, cc_r, cs_r;
  logic               vld_r;
  logic [107:0]       res_r, res_nxt;

  function automatic logic signed [PW-1:0] prod(input logic [LW-1:0] l,
                                                input logic signed [15:0] t);
    logic signed [LW+17:0] p;
    p = $signed({1'b0, l}) * t + (LW+18)'(16384);
    return PW'(p >>> 15);
  endfunction

  function automatic logic [17:0] sat18(input logic signed [SW-1:0] v);
    if (v > SW'(131071)) return 18'h1ffff;
    if (v < -SW'(131072)) return 18'h20000;
    return v[17:0];
  endfunction

  always_comb begin
    logic signed [SW-1:0] px, py, j00, j01, j10, j11;
    px  = SW'(tc_r) + SW'(cc_r);
    py  = SW'(ts_r) + SW'(cs_r);
    j01 = -SW'(cs_r);
    j00 = j01 - SW'(ts_r);
    j11 = SW'(cc_r);
    j10 = px;
    res_nxt = {sat18(j11), sat18(j10), sat18(j01), sat18(j00),
               sat18(py), sat18(px)};
  end

  assign ct = tlk_pkg::to_q15(a_i.x, a_i.flip);
  assign st = tlk_pkg::to_q15(a_i.y, a_i.flip);
  assign ck = tlk_pkg::to_q15(b_i.x, b_i.flip);
  assign sk = tlk_pkg::to_q15(b_i.y, b_i.flip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (!stall) begin
      p_vld_r <= vld_i;
      vld_r   <= p_vld_r;
    end
    if (!stall) begin
      tc_r  <= prod(tl_i, ct);
      ts_r  <= prod(tl_i, st);
      cc_r  <= prod(cl_i, ck);
      cs_r  <= prod(cl_i, sk);
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule

/* hw/rtl/two_link_forward_kinematics_jacobian_core.sv */
// ---------------------------------------------------------------------------
// two_link_forward_kinematics_jacobian_core
// Foot position and 2x2 Jacobian of a planar two-link leg.
// ---------------------------------------------------------------------------
// One pose (thigh angle, knee angle) enters per cycle and one result item
// leaves per cycle while the chain is not held. The path is one seed register,
// CORDIC_STAGES rotation cells (each rotating the thigh angle and the angle
// sum side by side), one product register and one output register. The
// whole chain advances together; it holds only when the output register is
// full and not taken, so in_tready = out_tready || !out_tvalid. The link
// lengths are sampled with the item at entry and travel along the chain.
// ---------------------------------------------------------------------------
module two_link_forward_kinematics_jacobian_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int LENGTH_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // upper_angle[15:0], lower_angle[31:16]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // pos_x, pos_y, jac_00, jac_01, jac_10,
                                   // jac_11 (18 bits each), zero pad
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int LW = LENGTH_BITS;
  localparam int N  = CORDIC_STAGES;

  logic [15:0] thigh_r, calf_r;
  logic        stall;

  // chain taps: index 0 is the seed register
  logic           vld  [0:N];
  tlk_pkg::cvec_t av   [0:N];
  tlk_pkg::cvec_t bv   [0:N];
  logic [LW-1:0]  tlv  [0:N];
  logic [LW-1:0]  clv  [0:N];

  logic           s_vld_r;
  tlk_pkg::cvec_t s_a_r, s_b_r;
  logic [LW-1:0]  s_tl_r, s_cl_r;
  logic [15:0]    sum_ang;
  logic [LW-1:0]  tl_in, cl_in;
  logic [107:0]   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thigh_r <= '0;
      calf_r  <= '0;
    end else if (cfg_we) begin
      if ({1'b0, cfg_addr} == tlk_pkg::CfgThigh) thigh_r <= cfg_wdata;
      if ({1'b0, cfg_addr} == tlk_pkg::CfgCalf)  calf_r  <= cfg_wdata;
    end
  end

  assign stall     = out_tvalid && !out_tready;
  assign in_tready = !stall;
  assign sum_ang   = in_tdata[15:0] + in_tdata[31:16];   // wraps a full turn

  // only the low LENGTH_BITS bits of a length count
  always_comb begin
    logic [39:0] t, c;
    t = 40'(thigh_r);
    c = 40'(calf_r);
    tl_in = t[LW-1:0];
    cl_in = c[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (!stall) begin
      s_vld_r <= in_tvalid;
    end
    if (!stall) begin
      s_a_r  <= tlk_pkg::cordic_seed(in_tdata[15:0]);
      s_b_r  <= tlk_pkg::cordic_seed(sum_ang);
      s_tl_r <= tl_in;
      s_cl_r <= cl_in;
    end
  end

  assign vld[0] = s_vld_r;
  assign av[0]  = s_a_r;
  assign bv[0]  = s_b_r;
  assign tlv[0] = s_tl_r;
  assign clv[0] = s_cl_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tlk_cordic_cell #(.STAGE(g), .LW(LW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .stall (stall),
      .vld_i (vld[g]),
      .a_i   (av[g]),
      .b_i   (bv[g]),
      .tl_i  (tlv[g]),
      .cl_i  (clv[g]),
      .vld_o (vld[g+1]),
      .a_o   (av[g+1]),
      .b_o   (bv[g+1]),
      .tl_o  (tlv[g+1]),
      .cl_o  (clv[g+1])
    );
  end

  tlk_combine #(.LW(LW)) u_comb (
    .clk   (clk),
    .rst_n (rst_n),
    .stall (stall),
    .vld_i (vld[N]),
    .a_i   (av[N]),
    .b_i   (bv[N]),
    .tl_i  (tlv[N]),
    .cl_i  (clv[N]),
    .vld_o (out_tvalid),
    .res_o (res)
  );

  assign out_tdata = {4'd0, res};

endmodule

/* hw/rtl/tlk_checker.sv */
// ---------------------------------------------------------------------------
// tlk_checker
// Port-level checks of the kinematics core.
// ---------------------------------------------------------------------------
`include "two_link_forward_kinematics_jacobian_core_macros.svh"

module tlk_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata
);

  `TLK_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  `TLK_ASSERT_IMP(a_ready_when_taken, clk, rst_n, out_tready, in_tready)
  `TLK_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata))
  `TLK_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[111:108] == 4'd0)

endmodule

bind two_link_forward_kinematics_jacobian_core tlk_checker u_tlk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/two_link_forward_kinematics_jacobian_core_tb.sv */
// ---------------------------------------------------------------------------
// two_link_forward_kinematics_jacobian_core_tb
// Self-checking bench for the two-link leg kinematics core.
// ---------------------------------------------------------------------------
// Every accepted pose is run through a bit-exact predictor: CORDIC sine and
// cosine, rounded length products, foot position and Jacobian. The predicted
// result item is queued. Each item leaving the core is checked, field by
// field, against the oldest queued prediction. The stimulus starts with
// directed angle corners. It then sends random poses under several link
// length settings, the extremes among them. Both sides idle at random,
// except in one long stretch where neither side idles.
// ---------------------------------------------------------------------------
module two_link_forward_kinematics_jacobian_core_tb;

  localparam int Stages     = 16;
  localparam int LenBits    = 16;
  localparam int Latency    = Stages + 4;
  localparam int CycleLimit = 400000;

  // one predicted result item
  typedef struct {
    logic signed [17:0] f [6];
  } leg_result_t;

  // Predicts the core from its configured lengths and holds the results still owed.
  class kinematics_scoreboard;
    leg_result_t owed_results[$];
    logic [15:0] thigh_len;
    logic [15:0] calf_len;
    int          mismatches;
    int          poses_in;
    int          results_out;
    longint      atan_turn[24];

    function new();
      atan_turn = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861, 10430, 5215,
                    2608, 1304, 652, 326, 163, 81};
      thigh_len = '0;
      calf_len  = '0;
    endfunction

    // Q1.15 cosine and sine of a binary angle
    function void sincos(input longint a, output longint c, output longint s);
      bit     flip;
      longint x, y, z, dx, dy, da;
      flip = 0;
      if (a > 16384) begin
        a -= 32768;
        flip = 1;
      end else if (a < -16384) begin
        a += 32768;
        flip = 1;
      end
      x = 652032874;
      y = 0;
      z = a * 65536;
      for (int i = 0; i < Stages; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        da = (i < 24) ? atan_turn[i] : 0;
        if (z >= 0) begin
          x -= dx; y += dy; z -= da;
        end else begin
          x += dx; y -= dy; z += da;
        end
      end
      x = (x + 16384) >>> 15;
      y = (y + 16384) >>> 15;
      if (x > 32767) x = 32767; else if (x < -32767) x = -32767;
      if (y > 32767) y = 32767; else if (y < -32767) y = -32767;
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint scale(input longint len, input longint t);
      return (len * t + 16384) >>> 15;
    endfunction

    function logic signed [17:0] clamp18(input longint v);
      if (v > 131071) v = 131071;
      else if (v < -131072) v = -131072;
      return v[17:0];
    endfunction

    function void note_pose(input logic signed [15:0] upper, input logic signed [15:0] lower);
      leg_result_t r;
      logic signed [15:0] knee_sum;
      longint ct, st, ck, sk, tc, ts, cc, cs, tl, cl;
      tl = thigh_len & ((64'd1 << LenBits) - 1);
      cl = calf_len  & ((64'd1 << LenBits) - 1);
      knee_sum = upper + lower;   // wraps a full turn
      sincos(longint'(upper), ct, st);
      sincos(longint'(knee_sum), ck, sk);
      tc = scale(tl, ct);
      ts = scale(tl, st);
      cc = scale(cl, ck);
      cs = scale(cl, sk);
      r.f[0] = clamp18(tc + cc);
      r.f[1] = clamp18(ts + cs);
      r.f[2] = clamp18(-ts - cs);
      r.f[3] = clamp18(-cs);
      r.f[4] = clamp18(tc + cc);
      r.f[5] = clamp18(cc);
      owed_results.push_back(r);
      poses_in++;
    endfunction

    function void check_result(input logic [111:0] data);
      leg_result_t want;
      string names[6];
      names = '{"pos_x", "pos_y", "jac_00", "jac_01", "jac_10", "jac_11"};
      results_out++;
      if (owed_results.size() == 0) begin
        $error("result item with no pose outstanding: %h", data);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      for (int k = 0; k < 6; k++)
        if (data[18*k +: 18] !== want.f[k]) begin
          $error("%s: expected %0d, got %0d", names[k], want.f[k],
                 $signed(data[18*k +: 18]));
          mismatches++;
        end
      if (data[111:108] !== 4'd0) begin
        $error("pad: expected 0, got %h", data[111:108]);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;    // upper_angle[15:0], lower_angle[31:16]
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [111:0] out_tdata;        // pos_x, pos_y, jac_00, jac_01, jac_10, jac_11, pad
  logic         cfg_we = 0;
  logic [0:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;

  kinematics_scoreboard sb = new();
  int  cycle_count = 0;
  bit  calm;   // long stretch with no idling on either side

  two_link_forward_kinematics_jacobian_core #(
    .CORDIC_STAGES(Stages),
    .LENGTH_BITS  (LenBits)
  ) u_top (.*);

  always #1 clk = ~clk;

  // cycle count, calm window and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    calm <= (cycle_count >= 3000 && cycle_count < 4500);
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check taken items, stall about 13 percent of the time outside the calm window
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 13);
  end

  // sends one pose; outside the calm window it may idle first
  task automatic send_pose(input logic [15:0] upper, input logic [15:0] lower);
    if (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lower, upper};
    do @(posedge clk); while (!in_tready);
    sb.note_pose(upper, lower);
  endtask

  // waits until the core is empty, then writes one length
  task automatic write_length(input logic [0:0] reg_sel, input logic [15:0] value);
    in_tvalid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= reg_sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_sel == 1'(tlk_pkg::CfgThigh)) sb.thigh_len = value;
    else sb.calf_len = value;
  endtask

  task automatic random_poses(input int n);
    logic [15:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = $urandom();
      b = $urandom();
      // bias some towards the fold boundaries and the wrap of the sum
      case ($urandom_range(7))
        0: a = 16'(16384 + $signed($urandom_range(4)) - 2);
        1: a = 16'(-16384 + $signed($urandom_range(4)) - 2);
        2: b = 16'(32768 - a + $signed($urandom_range(8)) - 4);
        default: ;
      endcase
      send_pose(a, b);
    end
  endtask

  logic [15:0] corner_angles[12] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000,
                                     16'hC000, 16'h4001, 16'hBFFF, 16'h3FFF, 16'hC001,
                                     16'h2000, 16'h0001};
  logic [15:0] length_sets[7][2] = '{'{16'hFFFF, 16'hFFFF}, '{16'h0000, 16'hFFFF},
                                     '{16'hFFFF, 16'h0000}, '{16'h4000, 16'h2A00},
                                     '{16'h0001, 16'h8000}, '{16'h0000, 16'h0000},
                                     '{16'h1234, 16'hFEDC}};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with long links: fold edges, pi, wrap of the angle sum
    write_length(1'(tlk_pkg::CfgThigh), 16'hFFFF);
    write_length(1'(tlk_pkg::CfgCalf), 16'hFFFF);
    for (int i = 0; i < 12; i++)
      send_pose(corner_angles[i], corner_angles[11 - i]);
    send_pose(16'h7FFF, 16'h7FFF);
    send_pose(16'h8000, 16'h8000);
    send_pose(16'h4000, 16'h4000);
    send_pose(16'hC000, 16'hC000);
    send_pose(16'h0000, 16'h8000);
    send_pose(16'h4001, 16'h3FFF);

    // sender holds off until every owed result has arrived
    in_tvalid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);

    for (int p = 0; p < 7; p++) begin
      write_length(1'(tlk_pkg::CfgThigh), length_sets[p][0]);
      write_length(1'(tlk_pkg::CfgCalf), length_sets[p][1]);
      random_poses(p == 0 ? 250 : 215);
    end
    in_tvalid <= 1'b0;

    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    $display("Covered %0d poses and %0d results over 8 link length settings,",
             sb.poses_in, sb.results_out);
    $display("incl. zero and full-scale links, fold edges and sum wrap.");
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tlk_pkg.sv
hw/rtl/tlk_cordic_cell.sv
hw/rtl/tlk_combine.sv
hw/rtl/two_link_forward_kinematics_jacobian_core.sv
hw/rtl/tlk_checker.sv
verif/two_link_forward_kinematics_jacobian_core_tb.sv
